@@ src/gps_pkg.sv @@
// ----------------------------------------------------------------------------
// Gripper pick-up sequencer package
// Item and result types, configuration layout, phase codes and command codes
// shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gps_pkg;

	// Sequencer phases, in the order of the result's phase code.
	typedef enum logic [3:0] {
		PH_INIT     = 4'd0,
		PH_APPROACH = 4'd1,
		PH_FINAL    = 4'd2,
		PH_CLOSE    = 4'd3,
		PH_UP       = 4'd4,
		PH_CONFIRM  = 4'd5,
		PH_COMPLETE = 4'd6,
		PH_FAIL     = 4'd7,
		PH_FAILED   = 4'd8
	} gps_phase_t;

	// Input item kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Gripper poses.
	localparam logic [1:0] POSE_DOWN_OPEN    = 2'd0;
	localparam logic [1:0] POSE_DOWN_CLOSED  = 2'd1;
	localparam logic [1:0] POSE_UP_CLOSED    = 2'd2;
	localparam logic [1:0] POSE_HOVER_CLOSED = 2'd3;

	// Waypoint commands.
	localparam logic [2:0] WP_NONE     = 3'd0;
	localparam logic [2:0] WP_APPROACH = 3'd1;
	localparam logic [2:0] WP_FORWARD  = 3'd2;
	localparam logic [2:0] WP_REVERSE  = 3'd3;
	localparam logic [2:0] WP_CLEAR    = 3'd4;

	// Leave requests.
	localparam logic [1:0] LEAVE_STAY   = 2'd0;
	localparam logic [1:0] LEAVE_HOME   = 2'd1;
	localparam logic [1:0] LEAVE_SEARCH = 2'd2;

	// Back-off distance used when a pick-up fails.
	localparam logic [15:0] REVERSE_MM = 16'd300;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPT_LIMIT    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_TIME_MS    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_UP_TIME_MS       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_TIME_MS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COMPLETE_HOLD_MS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SECURE_DIST_MM   = 3'd5;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration reset values.
	localparam logic [7:0]  RST_ATTEMPT_LIMIT    = 8'd5;
	localparam logic [15:0] RST_CLOSE_TIME_MS    = 16'd1000;
	localparam logic [15:0] RST_UP_TIME_MS       = 16'd1000;
	localparam logic [15:0] RST_CONFIRM_TIME_MS  = 16'd2000;
	localparam logic [15:0] RST_COMPLETE_HOLD_MS = 16'd1500;
	localparam logic [15:0] RST_SECURE_DIST_MM   = 16'd150;

	typedef struct packed {
		logic [7:0]  attempt_limit;
		logic [15:0] close_time_ms;
		logic [15:0] up_time_ms;
		logic [15:0] confirm_time_ms;
		logic [15:0] complete_hold_ms;
		logic [15:0] secure_distance_mm;
	} gps_cfg_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_ms;
		logic        cube_visible;
		logic [15:0] cube_distance_mm;
		logic        approach_arrived;
		logic        linear_arrived;
		logic        tag_seen;
		logic [15:0] tag_distance_mm;
	} gps_in_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [1:0]  gripper_pose;
		logic [2:0]  waypoint_cmd;
		logic [15:0] move_distance_mm;
		logic [1:0]  leave_request;
	} gps_out_t;

endpackage

`default_nettype wire

@@ src/gps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Gripper pick-up sequencer configuration registers
// Holds the six tuning registers and decodes writes from the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [gps_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  wire logic [gps_pkg::CFG_DATA_W-1:0]   wr_data,
	output gps_pkg::gps_cfg_t                     cfg
);

	gps_pkg::gps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attempt_limit      <= gps_pkg::RST_ATTEMPT_LIMIT;
			cfg_q.close_time_ms      <= gps_pkg::RST_CLOSE_TIME_MS;
			cfg_q.up_time_ms         <= gps_pkg::RST_UP_TIME_MS;
			cfg_q.confirm_time_ms    <= gps_pkg::RST_CONFIRM_TIME_MS;
			cfg_q.complete_hold_ms   <= gps_pkg::RST_COMPLETE_HOLD_MS;
			cfg_q.secure_distance_mm <= gps_pkg::RST_SECURE_DIST_MM;
		end else if (wr_en) begin
			// Writes to indexes past the last register are dropped.
			unique case (wr_index)
				gps_pkg::REG_ATTEMPT_LIMIT:    cfg_q.attempt_limit      <= wr_data[7:0];
				gps_pkg::REG_CLOSE_TIME_MS:    cfg_q.close_time_ms      <= wr_data;
				gps_pkg::REG_UP_TIME_MS:       cfg_q.up_time_ms         <= wr_data;
				gps_pkg::REG_CONFIRM_TIME_MS:  cfg_q.confirm_time_ms    <= wr_data;
				gps_pkg::REG_COMPLETE_HOLD_MS: cfg_q.complete_hold_ms   <= wr_data;
				gps_pkg::REG_SECURE_DIST_MM:   cfg_q.secure_distance_mm <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/gps_step.sv @@
// ----------------------------------------------------------------------------
// Gripper pick-up sequencer step
// Sequencer state and the combinational step logic: phase transition, then
// the action of the resulting phase, then the leave request.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               commit,
	input  wire gps_pkg::gps_in_t   item,
	input  wire gps_pkg::gps_cfg_t  cfg,
	output gps_pkg::gps_out_t       result
);

	gps_pkg::gps_phase_t phase_q, phase_d;
	logic [7:0]  attempt_q, attempt_d, attempt_inc;
	logic [31:0] start_q, start_d;
	logic        secured_q, secured_d;
	logic        appr_q, appr_d;
	logic        move_q, move_d;
	logic [1:0]  grip_q, grip_d;

	logic        tick;
	logic        appr_clr, move_clr, start_upd;
	logic        too_many;
	logic [31:0] elapsed, hold_elapsed;
	logic [2:0]  cmd;
	logic [15:0] move_dist;
	logic [1:0]  leave;

	assign tick        = (item.kind == gps_pkg::KIND_TICK);
	assign elapsed     = item.now_ms - start_q;
	assign too_many    = (attempt_q > cfg.attempt_limit);
	assign attempt_inc = (attempt_q == 8'hFF) ? attempt_q : attempt_q + 8'd1;

	// Next-phase logic: at most one transition per tick.
	always_comb begin
		phase_d   = phase_q;
		appr_clr  = 1'b0;
		move_clr  = 1'b0;
		start_upd = 1'b0;
		if (!tick) begin
			phase_d = gps_pkg::PH_INIT;
		end else begin
			unique case (phase_q)
				gps_pkg::PH_INIT: begin
					if (appr_q) begin
						phase_d = gps_pkg::PH_APPROACH;
					end else if (too_many) begin
						phase_d = gps_pkg::PH_FAILED;
					end
				end
				gps_pkg::PH_APPROACH: begin
					if (appr_q && item.approach_arrived) begin
						appr_clr = 1'b1;
						phase_d  = gps_pkg::PH_FINAL;
					end else if (too_many) begin
						phase_d = gps_pkg::PH_FAILED;
					end
				end
				gps_pkg::PH_FINAL: begin
					if (move_q && item.linear_arrived) begin
						move_clr  = 1'b1;
						start_upd = 1'b1;
						phase_d   = gps_pkg::PH_CLOSE;
					end
				end
				gps_pkg::PH_CLOSE: begin
					if (elapsed >= {16'd0, cfg.close_time_ms}) begin
						start_upd = 1'b1;
						phase_d   = gps_pkg::PH_UP;
					end
				end
				gps_pkg::PH_UP: begin
					if (elapsed >= {16'd0, cfg.up_time_ms}) begin
						start_upd = 1'b1;
						phase_d   = gps_pkg::PH_CONFIRM;
					end
				end
				gps_pkg::PH_CONFIRM: begin
					if (secured_q) begin
						start_upd = 1'b1;
						phase_d   = gps_pkg::PH_COMPLETE;
					end else if (elapsed >= {16'd0, cfg.confirm_time_ms}) begin
						phase_d = gps_pkg::PH_FAIL;
					end
				end
				gps_pkg::PH_FAIL: begin
					if (move_q && item.linear_arrived) begin
						phase_d = gps_pkg::PH_INIT;
					end
				end
				default: ;
			endcase
		end
	end

	// Once the phase moved to complete in this tick the timer restarts at zero.
	assign hold_elapsed = start_upd ? 32'd0 : elapsed;

	// Phase action, commands and state updates.
	always_comb begin
		appr_d    = appr_q;
		move_d    = move_q;
		attempt_d = attempt_q;
		secured_d = secured_q;
		grip_d    = grip_q;
		start_d   = start_upd ? item.now_ms : start_q;
		cmd       = gps_pkg::WP_NONE;
		move_dist = 16'd0;
		leave     = gps_pkg::LEAVE_STAY;
		if (!tick) begin
			attempt_d = 8'd0;
			secured_d = 1'b0;
			appr_d    = 1'b0;
			move_d    = 1'b0;
		end else begin
			if (appr_clr) begin
				appr_d = 1'b0;
			end
			if (move_clr) begin
				move_d = 1'b0;
			end
			if (appr_clr || move_clr) begin
				cmd = gps_pkg::WP_CLEAR;
			end
			if (phase_d != phase_q) begin
				if (phase_d == gps_pkg::PH_FINAL) begin
					move_d    = 1'b1;
					cmd       = gps_pkg::WP_FORWARD;
					move_dist = item.cube_distance_mm;
				end else if (phase_d == gps_pkg::PH_FAIL) begin
					move_d    = 1'b1;
					cmd       = gps_pkg::WP_REVERSE;
					move_dist = gps_pkg::REVERSE_MM;
				end
			end
			unique case (phase_d)
				gps_pkg::PH_INIT: begin
					if (item.cube_visible) begin
						appr_d    = 1'b1;
						cmd       = gps_pkg::WP_APPROACH;
						move_dist = 16'd0;
					end else begin
						attempt_d = attempt_inc;
					end
				end
				gps_pkg::PH_APPROACH: begin
					grip_d    = gps_pkg::POSE_DOWN_OPEN;
					attempt_d = item.tag_seen ? 8'd0 : attempt_inc;
				end
				gps_pkg::PH_FINAL:    grip_d = gps_pkg::POSE_DOWN_OPEN;
				gps_pkg::PH_CLOSE:    grip_d = gps_pkg::POSE_DOWN_CLOSED;
				gps_pkg::PH_UP:       grip_d = gps_pkg::POSE_UP_CLOSED;
				gps_pkg::PH_CONFIRM: begin
					if (item.tag_seen && (item.tag_distance_mm < cfg.secure_distance_mm)) begin
						secured_d = 1'b1;
					end
				end
				gps_pkg::PH_COMPLETE: grip_d = gps_pkg::POSE_HOVER_CLOSED;
				gps_pkg::PH_FAIL:     grip_d = gps_pkg::POSE_DOWN_OPEN;
				default: ;
			endcase
			if (phase_d == gps_pkg::PH_COMPLETE &&
			    hold_elapsed >= {16'd0, cfg.complete_hold_ms}) begin
				leave = gps_pkg::LEAVE_HOME;
			end else if (phase_d == gps_pkg::PH_FAILED) begin
				leave = gps_pkg::LEAVE_SEARCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= gps_pkg::PH_INIT;
			attempt_q <= 8'd0;
			start_q   <= 32'd0;
			secured_q <= 1'b0;
			appr_q    <= 1'b0;
			move_q    <= 1'b0;
			grip_q    <= gps_pkg::POSE_DOWN_OPEN;
		end else if (commit) begin
			phase_q   <= phase_d;
			attempt_q <= attempt_d;
			start_q   <= start_d;
			secured_q <= secured_d;
			appr_q    <= appr_d;
			move_q    <= move_d;
			grip_q    <= grip_d;
		end
	end

	assign result = {phase_d, grip_d, cmd, move_dist, leave};

endmodule

`default_nettype wire

@@ src/gripper_pickup_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Gripper pick-up sequencer unit
// Steps a gripper through cube pick-up, one request per control tick.
// ----------------------------------------------------------------------------
// Usage: each input request is either a start (kind 0), which returns the
// sequencer to its init phase, or a control tick (kind 1), which makes at most
// one phase transition and then performs that phase's action. Every input
// request produces exactly one result request carrying the phase, gripper
// pose, waypoint command with its distance, and a leave request.
// Both data channels use valid/stall: a request moves on a rising edge with
// valid high and stall low. Configuration is written through a separate
// valid/ready channel that is always ready; write it only while idle.
// The accepted request waits in the input register, then the step logic updates
// the state and fills the result register, from which the result is taken.
// Throughput is one request per cycle while the receiver does not stall, as
// the step logic is combinational. When the receiver stalls, the held
// result stays put and one further request can wait in the input register
// before in_stall rises.
// Reset clears the phase to init, all counters and flags to zero, and loads
// the configuration registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module gripper_pickup_sequencer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire gps_pkg::gps_in_t                 in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output gps_pkg::gps_out_t                     out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [gps_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [gps_pkg::CFG_DATA_W-1:0]   cfg_data
);

	gps_pkg::gps_cfg_t cfg;
	gps_pkg::gps_in_t  item_s1;
	gps_pkg::gps_out_t result;
	gps_pkg::gps_out_t out_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              accept;
	logic              advance;

	// The configuration channel never back-pressures.
	assign cfg_ready = 1'b1;

	gps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The request in the input register is stepped whenever the result
	// register is empty or its content is being taken this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// Step logic and sequencer state; state commits when the request advances.
	gps_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Gripper pick-up sequencer testbench
// Drives start and control-tick requests into the sequencer and checks every
// result request against a cycle-free model of the pick-up phases. The run
// opens with a short directed table and then runs random, mostly well-formed
// pick-up sequences under several configuration settings, with random stalls
// and gaps on both data channels.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned PHASE_REQUESTS = 200;
	localparam int unsigned NUM_PHASES     = 8;

	typedef struct {
		gps_pkg::gps_in_t  req;
		bit                typed;
		gps_pkg::gps_out_t want;
	} table_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	gps_pkg::gps_in_t                in_data;
	logic                            out_valid;
	logic                            out_stall;
	gps_pkg::gps_out_t               out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [gps_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [gps_pkg::CFG_DATA_W-1:0]  cfg_data;

	// Model state of the sequencer and its configuration.
	gps_pkg::gps_phase_t seq_phase;
	logic [7:0]          attempts;
	logic [31:0]         phase_t0;
	logic                secured;
	logic                approach_on;
	logic                move_on;
	logic [1:0]          pose;
	gps_pkg::gps_cfg_t   cfg_model;

	gps_pkg::gps_out_t due_steps[$];
	table_row_t        directed_rows[$];
	int unsigned       mismatches;
	int unsigned       idle_cycles;
	int unsigned       hold_left;
	logic [31:0]       sim_ms;
	logic              steady;
	logic              hold_req;

	gripper_pickup_sequencer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// Timers compare modulo-2^32 elapsed milliseconds.
	function automatic logic [31:0] ms_since(input logic [31:0] now);
		return now - phase_t0;
	endfunction

	task automatic bump_attempts();
		if (attempts != 8'hFF) begin
			attempts++;
		end
	endtask

	// One step of the pick-up sequence: transition first, then the action of
	// the phase that results, then the leave request.
	task automatic pickup_step(input gps_pkg::gps_in_t it, output gps_pkg::gps_out_t res);
		gps_pkg::gps_phase_t prev;
		gps_pkg::gps_phase_t nxt;
		logic [2:0]          cmd;
		logic [15:0]         move_dist;
		logic [1:0]          leave;
		cmd       = gps_pkg::WP_NONE;
		move_dist = 16'd0;
		leave     = gps_pkg::LEAVE_STAY;
		if (it.kind == gps_pkg::KIND_START) begin
			seq_phase   = gps_pkg::PH_INIT;
			attempts    = 8'd0;
			secured     = 1'b0;
			approach_on = 1'b0;
			move_on     = 1'b0;
		end else begin
			prev = seq_phase;
			nxt  = seq_phase;
			case (prev)
				gps_pkg::PH_INIT: begin
					if (approach_on) nxt = gps_pkg::PH_APPROACH;
					else if (attempts > cfg_model.attempt_limit) nxt = gps_pkg::PH_FAILED;
				end
				gps_pkg::PH_APPROACH: begin
					if (approach_on && it.approach_arrived) begin
						cmd         = gps_pkg::WP_CLEAR;
						approach_on = 1'b0;
						nxt         = gps_pkg::PH_FINAL;
					end else if (attempts > cfg_model.attempt_limit) begin
						nxt = gps_pkg::PH_FAILED;
					end
				end
				gps_pkg::PH_FINAL: begin
					if (move_on && it.linear_arrived) begin
						cmd      = gps_pkg::WP_CLEAR;
						move_on  = 1'b0;
						phase_t0 = it.now_ms;
						nxt      = gps_pkg::PH_CLOSE;
					end
				end
				gps_pkg::PH_CLOSE: begin
					if (ms_since(it.now_ms) >= {16'd0, cfg_model.close_time_ms}) begin
						nxt      = gps_pkg::PH_UP;
						phase_t0 = it.now_ms;
					end
				end
				gps_pkg::PH_UP: begin
					if (ms_since(it.now_ms) >= {16'd0, cfg_model.up_time_ms}) begin
						nxt      = gps_pkg::PH_CONFIRM;
						phase_t0 = it.now_ms;
					end
				end
				gps_pkg::PH_CONFIRM: begin
					if (secured) begin
						nxt      = gps_pkg::PH_COMPLETE;
						phase_t0 = it.now_ms;
					end else if (ms_since(it.now_ms) >= {16'd0, cfg_model.confirm_time_ms}) begin
						nxt = gps_pkg::PH_FAIL;
					end
				end
				gps_pkg::PH_FAIL: begin
					if (move_on && it.linear_arrived) nxt = gps_pkg::PH_INIT;
				end
				default: ;
			endcase
			seq_phase = nxt;
			if (nxt != prev) begin
				if (nxt == gps_pkg::PH_FINAL) begin
					move_on   = 1'b1;
					cmd       = gps_pkg::WP_FORWARD;
					move_dist = it.cube_distance_mm;
				end else if (nxt == gps_pkg::PH_FAIL) begin
					move_on   = 1'b1;
					cmd       = gps_pkg::WP_REVERSE;
					move_dist = gps_pkg::REVERSE_MM;
				end
			end
			case (seq_phase)
				gps_pkg::PH_INIT: begin
					if (it.cube_visible) begin
						approach_on = 1'b1;
						cmd         = gps_pkg::WP_APPROACH;
						move_dist   = 16'd0;
					end else begin
						bump_attempts();
					end
				end
				gps_pkg::PH_APPROACH: begin
					pose = gps_pkg::POSE_DOWN_OPEN;
					if (it.tag_seen) attempts = 8'd0;
					else bump_attempts();
				end
				gps_pkg::PH_FINAL:    pose = gps_pkg::POSE_DOWN_OPEN;
				gps_pkg::PH_CLOSE:    pose = gps_pkg::POSE_DOWN_CLOSED;
				gps_pkg::PH_UP:       pose = gps_pkg::POSE_UP_CLOSED;
				gps_pkg::PH_CONFIRM: begin
					if (it.tag_seen && it.tag_distance_mm < cfg_model.secure_distance_mm)
						secured = 1'b1;
				end
				gps_pkg::PH_COMPLETE: pose = gps_pkg::POSE_HOVER_CLOSED;
				gps_pkg::PH_FAIL:     pose = gps_pkg::POSE_DOWN_OPEN;
				default: ;
			endcase
			if (seq_phase == gps_pkg::PH_COMPLETE &&
			    ms_since(it.now_ms) >= {16'd0, cfg_model.complete_hold_ms}) begin
				leave = gps_pkg::LEAVE_HOME;
			end else if (seq_phase == gps_pkg::PH_FAILED) begin
				leave = gps_pkg::LEAVE_SEARCH;
			end
		end
		res.phase            = seq_phase;
		res.gripper_pose     = pose;
		res.waypoint_cmd     = cmd;
		res.move_distance_mm = move_dist;
		res.leave_request    = leave;
	endtask

	function automatic gps_pkg::gps_in_t pack_request(input logic kind, input logic [31:0] now,
			input logic cv, input logic [15:0] cd, input logic aa, input logic la,
			input logic ts, input logic [15:0] td);
		gps_pkg::gps_in_t it;
		it.kind             = kind;
		it.now_ms           = now;
		it.cube_visible     = cv;
		it.cube_distance_mm = cd;
		it.approach_arrived = aa;
		it.linear_arrived   = la;
		it.tag_seen         = ts;
		it.tag_distance_mm  = td;
		return it;
	endfunction

	function automatic void add_row(input gps_pkg::gps_in_t req, input bit typed,
			input gps_pkg::gps_out_t want);
		table_row_t row;
		row.req   = req;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	// Random tick shaped by the modeled phase so that most sequences get all
	// the way through pick-up; a share of starts and pure noise is mixed in.
	function automatic gps_pkg::gps_in_t make_random_request();
		gps_pkg::gps_in_t it;
		int unsigned      roll;
		logic [31:0]      span;
		it                  = '0;
		it.kind             = gps_pkg::KIND_TICK;
		it.cube_distance_mm = 16'($urandom_range(0, 65535));
		it.tag_distance_mm  = 16'($urandom_range(0, 65535));
		it.cube_visible     = 1'($urandom_range(0, 1));
		it.tag_seen         = 1'($urandom_range(0, 1));
		it.approach_arrived = ($urandom_range(0, 99) < 20);
		it.linear_arrived   = ($urandom_range(0, 99) < 20);
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			it.kind   = gps_pkg::KIND_START;
			it.now_ms = $urandom;
			return it;
		end
		if (roll < 12) begin
			it.now_ms           = $urandom;
			it.approach_arrived = 1'($urandom_range(0, 1));
			it.linear_arrived   = 1'($urandom_range(0, 1));
			return it;
		end
		span = 32'd50;
		case (seq_phase)
			gps_pkg::PH_INIT:     it.cube_visible = ($urandom_range(0, 99) < 60);
			gps_pkg::PH_APPROACH: it.approach_arrived = ($urandom_range(0, 99) < 40);
			gps_pkg::PH_FINAL:    it.linear_arrived = ($urandom_range(0, 99) < 50);
			gps_pkg::PH_FAIL:     it.linear_arrived = ($urandom_range(0, 99) < 50);
			gps_pkg::PH_CLOSE:    span = {16'd0, cfg_model.close_time_ms};
			gps_pkg::PH_UP:       span = {16'd0, cfg_model.up_time_ms};
			gps_pkg::PH_CONFIRM: begin
				span        = {16'd0, cfg_model.confirm_time_ms};
				it.tag_seen = ($urandom_range(0, 99) < 40);
				// Keep the tag distance mostly around the secure threshold.
				case ($urandom_range(0, 3))
					0: it.tag_distance_mm = cfg_model.secure_distance_mm - 16'd1;
					1: it.tag_distance_mm = cfg_model.secure_distance_mm;
					2: it.tag_distance_mm = 16'd0;
					default: ;
				endcase
			end
			gps_pkg::PH_COMPLETE: begin
				span = {16'd0, cfg_model.complete_hold_ms};
				if ($urandom_range(0, 99) < 15) it.kind = gps_pkg::KIND_START;
			end
			gps_pkg::PH_FAILED: begin
				if ($urandom_range(0, 99) < 25) it.kind = gps_pkg::KIND_START;
			end
			default: ;
		endcase
		if ($urandom_range(0, 99) < 4) sim_ms = sim_ms + $urandom;
		else sim_ms = sim_ms + $urandom_range(0, span / 2 + 2);
		it.now_ms = sim_ms;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_request(input gps_pkg::gps_in_t req, input bit typed,
			input gps_pkg::gps_out_t want);
		gps_pkg::gps_out_t predicted;
		if (!steady && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pickup_step(req, predicted);
		due_steps.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Drop valid and wait for every result, plus some margin, so that the
	// block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_steps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [gps_pkg::CFG_INDEX_W-1:0] idx,
			input logic [gps_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			gps_pkg::REG_ATTEMPT_LIMIT:    cfg_model.attempt_limit      = val[7:0];
			gps_pkg::REG_CLOSE_TIME_MS:    cfg_model.close_time_ms      = val;
			gps_pkg::REG_UP_TIME_MS:       cfg_model.up_time_ms         = val;
			gps_pkg::REG_CONFIRM_TIME_MS:  cfg_model.confirm_time_ms    = val;
			gps_pkg::REG_COMPLETE_HOLD_MS: cfg_model.complete_hold_ms   = val;
			gps_pkg::REG_SECURE_DIST_MM:   cfg_model.secure_distance_mm = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Phase one is all zero, phase two all at the top but attempt limit 254, phase
	// three short timers and few attempts, the rest spread over the full ranges but attempt limit <= 254.
	task automatic retune(input int unsigned ph);
		logic [15:0] v[6];
		case (ph)
			1: begin
				foreach (v[k]) v[k] = 16'd0;
			end
			2: begin
				foreach (v[k]) v[k] = 16'hFFFF;
				v[gps_pkg::REG_ATTEMPT_LIMIT] = 16'd254;
			end
			3: begin
				foreach (v[k]) v[k] = 16'($urandom_range(0, 400));
				v[gps_pkg::REG_ATTEMPT_LIMIT] = 16'($urandom_range(0, 8));
			end
			default: begin
				foreach (v[k]) v[k] = 16'($urandom_range(0, 65535));
				v[gps_pkg::REG_ATTEMPT_LIMIT] = 16'($urandom_range(0, 254));
			end
		endcase
		write_reg(gps_pkg::REG_ATTEMPT_LIMIT, v[gps_pkg::REG_ATTEMPT_LIMIT]);
		write_reg(gps_pkg::REG_CLOSE_TIME_MS, v[gps_pkg::REG_CLOSE_TIME_MS]);
		write_reg(gps_pkg::REG_UP_TIME_MS, v[gps_pkg::REG_UP_TIME_MS]);
		write_reg(gps_pkg::REG_CONFIRM_TIME_MS, v[gps_pkg::REG_CONFIRM_TIME_MS]);
		write_reg(gps_pkg::REG_COMPLETE_HOLD_MS, v[gps_pkg::REG_COMPLETE_HOLD_MS]);
		write_reg(gps_pkg::REG_SECURE_DIST_MM, v[gps_pkg::REG_SECURE_DIST_MM]);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, none while steady, and one long hold-off on
	// request from the stimulus.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req <= 1'b0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 20);
		end
	end

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		gps_pkg::gps_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_steps.size() == 0) begin
				flag_mismatch($sformatf("result %h with nothing due", out_data));
			end else begin
				want = due_steps.pop_front();
				if (out_data.phase !== want.phase)
					flag_mismatch($sformatf("phase %0d, want %0d",
						out_data.phase, want.phase));
				if (out_data.gripper_pose !== want.gripper_pose)
					flag_mismatch($sformatf("gripper_pose %0d, want %0d",
						out_data.gripper_pose, want.gripper_pose));
				if (out_data.waypoint_cmd !== want.waypoint_cmd)
					flag_mismatch($sformatf("waypoint_cmd %0d, want %0d",
						out_data.waypoint_cmd, want.waypoint_cmd));
				if (out_data.move_distance_mm !== want.move_distance_mm)
					flag_mismatch($sformatf("move_distance_mm %0d, want %0d",
						out_data.move_distance_mm, want.move_distance_mm));
				if (out_data.leave_request !== want.leave_request)
					flag_mismatch($sformatf("leave_request %0d, want %0d",
						out_data.leave_request, want.leave_request));
			end
		end
	end

	// Watchdog on cycles in which no channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		gps_pkg::gps_out_t none_due;
		none_due    = '0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		steady      = 1'b0;
		hold_req    = 1'b0;
		hold_left   = 0;
		mismatches  = 0;
		idle_cycles = 0;
		seq_phase   = gps_pkg::PH_INIT;
		attempts    = 8'd0;
		phase_t0    = 32'd0;
		secured     = 1'b0;
		approach_on = 1'b0;
		move_on     = 1'b0;
		pose        = gps_pkg::POSE_DOWN_OPEN;
		cfg_model.attempt_limit      = gps_pkg::RST_ATTEMPT_LIMIT;
		cfg_model.close_time_ms      = gps_pkg::RST_CLOSE_TIME_MS;
		cfg_model.up_time_ms         = gps_pkg::RST_UP_TIME_MS;
		cfg_model.confirm_time_ms    = gps_pkg::RST_CONFIRM_TIME_MS;
		cfg_model.complete_hold_ms   = gps_pkg::RST_COMPLETE_HOLD_MS;
		cfg_model.secure_distance_mm = gps_pkg::RST_SECURE_DIST_MM;

		// Directed table at reset configuration: a full successful pick-up
		// with the close timer wrapping through zero, a restart that keeps the
		// hover pose, a pick-up that times out in confirm and backs off, and
		// attempts running out in init.
		add_row(pack_request(gps_pkg::KIND_START, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_INIT, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_NONE, 16'd0, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_INIT, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_NONE, 16'd0, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd5, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_INIT, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_APPROACH, 16'd0, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd10, 1'b1, 16'h1234, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd20, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_FINAL, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_FORWARD, 16'hFFFF, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'hFFFF_FF00, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'h0000_02E7, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'h0000_02E8, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd1744, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1,
			16'd149), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd1745, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd3245, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_START, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1,
			1'b1, 16'hFFFF), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_INIT,
			gps_pkg::POSE_HOVER_CLOSED, gps_pkg::WP_NONE, 16'd0, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd100, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_INIT, gps_pkg::POSE_HOVER_CLOSED,
			gps_pkg::WP_APPROACH, 16'd0, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd110, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd120, 1'b0, 16'd0, 1'b1, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_FINAL, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_FORWARD, 16'd0, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd1000, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd2000, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1,
			16'd150), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd4000, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_FAIL, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_REVERSE, gps_pkg::REVERSE_MM, gps_pkg::LEAVE_STAY});
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd4010, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0,
			16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_START, 32'd4020, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_INIT, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_NONE, 16'd0, gps_pkg::LEAVE_STAY});
		for (int unsigned n = 0; n < 6; n++)
			add_row(pack_request(gps_pkg::KIND_TICK, 32'd5000 + n, 1'b0, 16'd0, 1'b0, 1'b0,
				1'b0, 16'd0), 1'b0, none_due);
		add_row(pack_request(gps_pkg::KIND_TICK, 32'd5010, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
			16'd0), 1'b1, gps_pkg::gps_out_t'{gps_pkg::PH_FAILED, gps_pkg::POSE_DOWN_OPEN,
			gps_pkg::WP_NONE, 16'd0, gps_pkg::LEAVE_SEARCH});

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			offer_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want);

		sim_ms = $urandom;
		for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				retune(ph);
			end
			// Phases four and five run with no idling on either side, apart
			// from the deliberate hold-off of the receiver in phase four.
			steady <= (ph == 4 || ph == 5);
			for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
				if (ph == 4 && n == 20) hold_req <= 1'b1;
				if (ph == 3 && n == 100) settle();
				offer_request(make_random_request(), 1'b0, none_due);
			end
		end

		in_valid <= 1'b0;
		while (due_steps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_steps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
